// ===== sv/kpd_pkg.sv =====
// Shared types and constants for the keypad scan, debounce and combo block.
// Used by kpd_engine and keypad_scan_debounce_combo_core; no dependencies.
package kpd_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;
    localparam int SCAN_COLS = (COLS < 4) ? COLS : 4;

    localparam int TICK_W = 16;
    localparam int KEY_W = 4;
    localparam int HIST_DEPTH = 3;

    localparam logic [KEY_W-1:0] KEY_D_POS = 4'd15;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_ROW_EDGE = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_WINDOW = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic fire;
        logic [KEY_W-1:0] key_position;
        logic triple_d;
    } kpd_result_t;

endpackage

// ===== sv/kpd_engine.sv =====
// Debounce timer, column scan, key history and triple-D combo detection.
// Processes one accepted beat per cycle; depends on kpd_pkg.
module kpd_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [kpd_pkg::TICK_W-1:0]  cfg_data,
    input  logic                        in_accept,
    input  logic                        in_cmd,
    input  logic [1:0]                  in_row_index,
    input  logic [3:0]                  in_column_levels,
    output kpd_pkg::kpd_result_t        result
);

    logic [kpd_pkg::TICK_W-1:0] debounce_reg;
    logic [kpd_pkg::TICK_W-1:0] window_reg;
    logic [kpd_pkg::TICK_W-1:0] since_reg, since_next;
    logic [kpd_pkg::KEY_W-1:0]  key_reg [kpd_pkg::HIST_DEPTH];
    logic [kpd_pkg::KEY_W-1:0]  key_next [kpd_pkg::HIST_DEPTH];
    logic [kpd_pkg::TICK_W-1:0] age_reg [kpd_pkg::HIST_DEPTH];
    logic [kpd_pkg::TICK_W-1:0] age_next [kpd_pkg::HIST_DEPTH];
    logic [kpd_pkg::HIST_DEPTH-1:0] valid_reg, valid_next;

    logic                       row_ok;
    logic                       found;
    logic [2:0]                 col_sel;
    logic [4:0]                 pos_full;
    logic [kpd_pkg::KEY_W-1:0]  pos;

    assign row_ok = {2'b00, in_row_index} < 4'(kpd_pkg::ROWS);

    always_comb begin
        found = 1'b0;
        col_sel = '0;
        for (int c = kpd_pkg::SCAN_COLS - 1; c >= 0; c--) begin
            if (!in_column_levels[c]) begin
                found = 1'b1;
                col_sel = 3'(c);
            end
        end
        pos_full = 5'(in_row_index) * 5'(kpd_pkg::COLS) + 5'(col_sel);
        pos = pos_full[kpd_pkg::KEY_W-1:0];
    end

    always_comb begin
        since_next = since_reg;
        valid_next = valid_reg;
        for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
            key_next[i] = key_reg[i];
            age_next[i] = age_reg[i];
        end
        result = '0;
        if (in_accept) begin
            if (in_cmd == kpd_pkg::CMD_TICK) begin
                since_next = (since_reg == '1) ? since_reg : since_reg + 1'b1;
                for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
                    age_next[i] = (age_reg[i] == '1) ? age_reg[i] : age_reg[i] + 1'b1;
                end
            end else if (row_ok && since_reg >= debounce_reg) begin
                since_next = '0;
                if (found) begin
                    for (int i = kpd_pkg::HIST_DEPTH - 1; i > 0; i--) begin
                        key_next[i] = key_reg[i-1];
                        age_next[i] = age_reg[i-1];
                        valid_next[i] = valid_reg[i-1];
                    end
                    key_next[0] = pos;
                    age_next[0] = '0;
                    valid_next[0] = 1'b1;
                    result.fire = 1'b1;
                    result.key_position = pos;
                    result.triple_d = valid_reg[0] && valid_reg[1]
                        && key_reg[0] == kpd_pkg::KEY_D_POS
                        && key_reg[1] == kpd_pkg::KEY_D_POS
                        && pos == kpd_pkg::KEY_D_POS
                        && age_reg[1] < window_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= kpd_pkg::DEBOUNCE_RESET;
            window_reg <= kpd_pkg::WINDOW_RESET;
            since_reg <= '0;
            valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    kpd_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                    kpd_pkg::REG_WINDOW:   window_reg <= cfg_data;
                    default: ;
                endcase
            end
            since_reg <= since_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
                key_reg[i] <= '0;
                age_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
                key_reg[i] <= key_next[i];
                age_reg[i] <= age_next[i];
            end
        end
    end

    a_fire_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        result.fire |=> since_reg == '0)
        else $error("debounce timer not restarted after a reported key");

    a_fire_pushes_history: assert property (@(posedge aclk) disable iff (!aresetn)
        result.fire |=> valid_reg[0] && key_reg[0] == $past(result.key_position)
            && age_reg[0] == '0)
        else $error("reported key not pushed into history");

    a_tick_never_fires: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_cmd == kpd_pkg::CMD_TICK) |-> !result.fire)
        else $error("tick beat produced a result");

    a_triple_is_d: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.fire && result.triple_d) |-> result.key_position == kpd_pkg::KEY_D_POS
            && valid_reg[1])
        else $error("combo flagged without D keys in history");

    a_valid_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (!valid_reg[2] || valid_reg[1]) && (!valid_reg[1] || valid_reg[0]))
        else $error("history valid bits out of order");

endmodule

// ===== sv/keypad_scan_debounce_combo_core.sv =====
// Keypad scan, debounce and triple-D combo block: stream ports and result register.
// Depends on kpd_pkg and kpd_engine.
//
// Usage: the input stream carries tick beats (s_tuser = 0), one per millisecond,
// and row-edge beats (s_tuser = 1) with the row index and the sampled column
// levels in s_tdata. An accepted edge that follows at least debounce_ticks
// ticks after the last edge that passed this check and shows a low column yields one
// result beat: the key position and the triple-D flag. Other beats yield none.
// The configuration port writes debounce_ticks (index 0) and
// combo_window_ticks (index 1), with no read-back.
// Throughput is one input beat per cycle while s_tready is high; the whole update is done by the
// logic between the input handshake and the result register, so a result
// appears on the output in the cycle after its edge is accepted.
// s_tready stays high while the result register is empty or being taken; if
// the receiver stalls with a result pending, s_tready drops until it is taken.
// Reset restores the register defaults (200 and 1000), clears the timer and
// empties the key history and the result register.
module keypad_scan_debounce_combo_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // row_index[1:0], column_levels[5:2], zero fill
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // key_position[3:0], triple_d[4], zero fill
);

    kpd_pkg::kpd_result_t result;
    logic                 in_accept;
    logic                 m_valid_reg;
    logic [4:0]           m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    kpd_engine u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_accept        (in_accept),
        .in_cmd           (s_tuser),
        .in_row_index     (s_tdata[1:0]),
        .in_column_levels (s_tdata[5:2]),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.fire) begin
            m_data_reg <= {result.triple_d, result.key_position};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'b000, m_data_reg};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for keypad_scan_debounce_combo_core: debounce, key scan and triple-D combo.
// Drives a directed plan and then random tick and row-edge beats, and checks every result beat.
// Depends on kpd_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 500;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_AFTER = 950;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_TICK,
        STEP_EDGE
    } step_kind_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_RESULT
    } check_t;

    typedef struct packed {
        logic [kpd_pkg::KEY_W-1:0] key;
        logic                      triple;
    } press_beat_t;

    typedef struct packed {
        step_kind_t                 kind;
        int unsigned                count;
        logic [1:0]                 row;
        logic [3:0]                 cols;
        kpd_pkg::reg_index_t        idx;
        logic [kpd_pkg::TICK_W-1:0] value;
        check_t                     chk;
        press_beat_t                want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    logic [kpd_pkg::TICK_W-1:0] cfg_debounce = kpd_pkg::DEBOUNCE_RESET;
    logic [kpd_pkg::TICK_W-1:0] cfg_window = kpd_pkg::WINDOW_RESET;
    logic [kpd_pkg::TICK_W-1:0] since_press = '0;
    logic [kpd_pkg::KEY_W-1:0]  hist_key[kpd_pkg::HIST_DEPTH];
    logic [kpd_pkg::TICK_W-1:0] hist_age[kpd_pkg::HIST_DEPTH];
    bit                         hist_valid[kpd_pkg::HIST_DEPTH];

    press_beat_t pending_keys[$];
    plan_row_t   plan[$];
    int          fail_count = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;

    keypad_scan_debounce_combo_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endfunction

    function automatic bit keypad_predict(input kpd_pkg::cmd_t cmd, input logic [1:0] row,
                                          input logic [3:0] cols, output press_beat_t ev);
        bit                        found;
        int                        pos_int;
        logic [kpd_pkg::KEY_W-1:0] pos;
        ev = '0;
        found = 1'b0;
        pos_int = 0;
        pos = '0;
        if (cmd == kpd_pkg::CMD_TICK) begin
            if (since_press != '1) since_press++;
            for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
                if (hist_age[i] != '1) hist_age[i]++;
            end
            return 1'b0;
        end
        if (int'(row) >= kpd_pkg::ROWS || since_press < cfg_debounce) return 1'b0;
        since_press = '0;
        for (int c = kpd_pkg::SCAN_COLS - 1; c >= 0; c--) begin
            if (!cols[c]) begin
                pos_int = int'(row) * kpd_pkg::COLS + c;
                pos = pos_int[kpd_pkg::KEY_W-1:0];
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        for (int i = kpd_pkg::HIST_DEPTH - 1; i > 0; i--) begin
            hist_key[i] = hist_key[i-1];
            hist_age[i] = hist_age[i-1];
            hist_valid[i] = hist_valid[i-1];
        end
        hist_key[0] = pos;
        hist_age[0] = '0;
        hist_valid[0] = 1'b1;
        ev.key = pos;
        ev.triple = hist_age[kpd_pkg::HIST_DEPTH-1] < cfg_window;
        for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
            if (!hist_valid[i] || hist_key[i] != kpd_pkg::KEY_D_POS) ev.triple = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic plan_row_t cfg_row(input kpd_pkg::reg_index_t idx,
                                          input logic [15:0] value);
        return plan_row_t'{STEP_CFG, 0, 2'd0, 4'd0, idx, value, CHK_PREDICT,
                           press_beat_t'(0)};
    endfunction

    function automatic plan_row_t tick_row(input int unsigned n);
        return plan_row_t'{STEP_TICK, n, 2'd0, 4'd0, kpd_pkg::REG_DEBOUNCE, 16'd0,
                           CHK_PREDICT, press_beat_t'(0)};
    endfunction

    function automatic plan_row_t edge_row(input logic [1:0] row, input logic [3:0] cols,
                                           input check_t chk, input logic [3:0] key,
                                           input logic triple);
        return plan_row_t'{STEP_EDGE, 1, row, cols, kpd_pkg::REG_DEBOUNCE, 16'd0, chk,
                           press_beat_t'{key, triple}};
    endfunction

    task automatic send_beat(input kpd_pkg::cmd_t cmd, input logic [1:0] row,
                             input logic [3:0] cols, input check_t chk,
                             input press_beat_t want);
        int          gap;
        bit          has_ev;
        press_beat_t ev;
        if (!quiet && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, cols, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has_ev = keypad_predict(cmd, row, cols, ev);
        if (chk == CHK_RESULT) begin
            pending_keys.push_back(want);
        end else if (chk == CHK_PREDICT && has_ev) begin
            pending_keys.push_back(ev);
        end
    endtask

    task automatic write_reg(input kpd_pkg::reg_index_t idx, input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == kpd_pkg::REG_DEBOUNCE) begin
            cfg_debounce = value;
        end else begin
            cfg_window = value;
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        press_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_keys.size() == 0) begin
                note_fail($sformatf("unexpected result beat, tdata 0x%02h", m_tdata));
            end else begin
                want = pending_keys.pop_front();
                if (m_tdata[3:0] !== want.key) begin
                    note_fail($sformatf("key_position expected %0d, got %0d",
                                        want.key, m_tdata[3:0]));
                end
                if (m_tdata[4] !== want.triple) begin
                    note_fail($sformatf("triple_d expected %0d, got %0d (key %0d)",
                                        want.triple, m_tdata[4], want.key));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int            deb_set[6];
        int            win_set[6];
        int            rand_items;
        int            n;
        logic [1:0]    row;
        logic [3:0]    cols;
        kpd_pkg::cmd_t cmd;

        for (int i = 0; i < kpd_pkg::HIST_DEPTH; i++) begin
            hist_key[i] = '0;
            hist_age[i] = '0;
            hist_valid[i] = 1'b0;
        end

        plan.push_back(edge_row(2'd0, 4'b0000, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(tick_row(200));
        plan.push_back(edge_row(2'd0, 4'b1110, CHK_RESULT, 4'd0, 1'b0));
        plan.push_back(edge_row(2'd0, 4'b0000, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(cfg_row(kpd_pkg::REG_DEBOUNCE, 16'd2));
        plan.push_back(cfg_row(kpd_pkg::REG_WINDOW, 16'd6));
        plan.push_back(tick_row(2));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_RESULT, 4'd15, 1'b0));
        plan.push_back(tick_row(1));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(tick_row(1));
        plan.push_back(edge_row(2'd3, 4'b1111, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(tick_row(1));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(tick_row(1));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_RESULT, 4'd15, 1'b0));
        plan.push_back(tick_row(2));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(tick_row(2));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(tick_row(2));
        plan.push_back(edge_row(2'd1, 4'b1101, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(tick_row(2));
        plan.push_back(edge_row(2'd2, 4'b1011, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(tick_row(3));
        plan.push_back(edge_row(2'd2, 4'b0000, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(cfg_row(kpd_pkg::REG_WINDOW, 16'd0));
        plan.push_back(cfg_row(kpd_pkg::REG_DEBOUNCE, 16'd0));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_RESULT, 4'd15, 1'b0));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_RESULT, 4'd15, 1'b0));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_RESULT, 4'd15, 1'b0));
        plan.push_back(cfg_row(kpd_pkg::REG_WINDOW, 16'hFFFF));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_PREDICT, 4'd0, 1'b0));
        plan.push_back(cfg_row(kpd_pkg::REG_DEBOUNCE, 16'hFFFF));
        plan.push_back(tick_row(8));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_SILENT, 4'd0, 1'b0));
        plan.push_back(edge_row(2'd3, 4'b0111, CHK_SILENT, 4'd0, 1'b0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_CFG: begin
                    write_reg(plan[i].idx, plan[i].value);
                end
                STEP_TICK: begin
                    repeat (plan[i].count) begin
                        send_beat(kpd_pkg::CMD_TICK, 2'd0, 4'd0, CHK_PREDICT, plan[i].want);
                    end
                end
                default: begin
                    send_beat(kpd_pkg::CMD_ROW_EDGE, plan[i].row, plan[i].cols,
                              plan[i].chk, plan[i].want);
                end
            endcase
        end

        deb_set = '{0, 1, 4, 2, $urandom_range(0, 6), 3};
        win_set = '{0, 65535, 12, 1, $urandom_range(0, 30), 30};
        rand_items = 0;
        for (int p = 0; p < 6; p++) begin
            write_reg(kpd_pkg::REG_DEBOUNCE, 16'(deb_set[p]));
            write_reg(kpd_pkg::REG_WINDOW, 16'(win_set[p]));
            while (rand_items < (p + 1) * (RANDOM_ITEMS / 6)) begin
                quiet = rand_items >= QUIET_AFTER;
                if ($urandom_range(0, 9) < 7) begin
                    n = $urandom_range(deb_set[p], deb_set[p] + 3);
                    if (deb_set[p] > 0 && $urandom_range(0, 7) == 0) n = deb_set[p] - 1;
                    repeat (n) begin
                        send_beat(kpd_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
                                  4'($urandom_range(0, 15)), CHK_PREDICT, '0);
                        rand_items++;
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        row = 2'd3;
                        cols = 4'b0111;
                    end else begin
                        row = 2'($urandom_range(0, 3));
                        cols = 4'($urandom_range(0, 15));
                    end
                    send_beat(kpd_pkg::CMD_ROW_EDGE, row, cols, CHK_PREDICT, '0);
                end else begin
                    cmd = kpd_pkg::cmd_t'($urandom_range(0, 1));
                    send_beat(cmd, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              CHK_PREDICT, '0);
                end
                rand_items++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_keys.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
